### src/tsmf_pkg.sv
package tsmf_pkg;

    localparam int MAX_WINDOW_DEF  = 63;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RING_DEPTH      = 64;
    localparam int RING_AW         = 6;
    localparam int CNT_W           = 7;
    localparam int WIN_W           = 6;

    localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd0;
    localparam logic [1:0] CFG_PADDING_MODE = 2'd1;
    localparam logic [1:0] CFG_DROP_FRAC    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic       wr_sample;   // store accepted sample, bump samples_seen
        logic       start_out;   // latch window geometry for next output
        logic       gather;      // read one window tap from ring
        logic       sort_step;   // one odd/even transposition pass
        logic       emit;        // load output register
        logic       bump_out;    // bump outputs_emitted
        logic       clear_cnt;   // series end: counters back to zero
        logic [WIN_W-1:0] tap;   // window tap index k
    } tsmf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       known;
        logic       more;        // another output due
        logic [WIN_W-1:0] w;     // effective window length
        logic       out_busy;    // output register full and not taken
    } tsmf_sts_t;

    function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] c);
        bump_count = (c >= CNT_W'(127)) ? CNT_W'(64) : c + CNT_W'(1);
    endfunction

endpackage

### src/tsmf_ctrl.sv
module tsmf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_series_end,
    input  tsmf_pkg::tsmf_sts_t   sts,
    output tsmf_pkg::tsmf_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_GATHER = 3'd2;
    localparam logic [2:0] ST_SORT   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       end_reg, end_next;
    logic [tsmf_pkg::WIN_W-1:0] k_reg, k_next;
    logic [tsmf_pkg::WIN_W:0]   pass_reg, pass_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        end_next   = end_reg;
        k_next     = k_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        cmd.tap    = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.wr_sample = 1'b1;
                    end_next      = s_series_end;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if ((sts.known || end_reg) && sts.more) begin
                    cmd.start_out = 1'b1;
                    k_next        = '0;
                    state_next    = ST_GATHER;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_GATHER: begin
                cmd.gather = 1'b1;
                k_next     = k_reg + 1'b1;
                if (k_reg == sts.w - 1'b1) begin
                    pass_next  = '0;
                    state_next = ST_SORT;
                end
            end
            ST_SORT: begin
                // pass 0 lets the last ring read land in the window
                cmd.sort_step = (pass_reg != '0);
                pass_next     = pass_reg + 1'b1;
                if (pass_reg == ({1'b0, sts.w} + 1'b1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!sts.out_busy) begin
                    cmd.emit     = 1'b1;
                    cmd.bump_out = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_DONE: begin
                cmd.clear_cnt = end_reg;
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            end_reg   <= 1'b0;
            k_reg     <= '0;
            pass_reg  <= '0;
        end else begin
            state_reg <= state_next;
            end_reg   <= end_next;
            k_reg     <= k_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

### src/tsmf_dp.sv
module tsmf_dp #(
    parameter int MAX_WINDOW  = tsmf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = tsmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                         s_series_end,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [7:0]                   cfg_data,
    input  tsmf_pkg::tsmf_cmd_t          cmd,
    output tsmf_pkg::tsmf_sts_t          sts,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [SAMPLE_BITS:0]  m_median_x2,
    output logic                         m_last_of_series
);

    localparam int CW = tsmf_pkg::CNT_W;
    localparam int WW = tsmf_pkg::WIN_W;
    localparam int AW = tsmf_pkg::RING_AW;

    logic signed [SAMPLE_BITS-1:0] ring [tsmf_pkg::RING_DEPTH];

    logic [WW-1:0] win_size_reg;
    logic          pad_reg;
    logic [7:0]    frac_reg;
    logic [CW-1:0] seen_reg, emitted_reg;
    logic          end_reg;

    logic [WW-1:0] w_reg, v1_reg, m_reg;
    logic          pexact_reg;
    logic [AW-1:0] p_reg, rem_reg;
    logic          last_reg;

    logic signed [SAMPLE_BITS-1:0] win_reg [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic                          rd_vld_reg;
    logic [WW-1:0]                 rd_k_reg;
    logic                          sort_par_reg;

    logic          m_valid_reg;
    logic signed [SAMPLE_BITS:0] med_reg;
    logic          mlast_reg;

    // effective window
    logic [WW-1:0] w_cfg, w_eff, v1_c, v2_c, r_c, m_c;
    logic [13:0]   rprod;
    logic          known_c;
    logic [AW-1:0] lag_c;
    always_comb begin
        w_cfg = (win_size_reg == '0) ? WW'(1) : win_size_reg;
        if (w_cfg > WW'(MAX_WINDOW)) w_cfg = WW'(MAX_WINDOW);
        known_c = (seen_reg >= CW'(64)) || (seen_reg >= {1'b0, w_cfg});
        w_eff   = known_c ? w_cfg : seen_reg[WW-1:0];
        v1_c    = w_eff >> 1;
        v2_c    = w_eff[0] ? v1_c : v1_c - 1'b1;
        rprod   = frac_reg * w_eff;
        r_c     = rprod[13:8];
        m_c     = w_eff - r_c;
        lag_c   = AW'(seen_reg - emitted_reg);
    end

    assign sts.known    = known_c;
    assign sts.more     = (lag_c != '0) && (end_reg || lag_c > v2_c);
    assign sts.w        = w_reg;
    assign sts.out_busy = m_valid_reg;

    // tap address
    logic signed [8:0] o_c, off_c, p_s, rem_s, beyond_c;
    always_comb begin
        p_s      = {3'b0, p_reg};
        rem_s    = {3'b0, rem_reg};
        o_c      = $signed({3'b0, cmd.tap}) - $signed({3'b0, v1_reg});
        beyond_c = o_c - rem_s + 9'sd1;
        off_c    = o_c;
        if (pexact_reg && o_c < -p_s)
            off_c = pad_reg ? (-(p_s <<< 1) - o_c) : -p_s;
        else if (o_c >= rem_s)
            off_c = pad_reg ? (rem_s - 9'sd1 - beyond_c) : (rem_s - 9'sd1);
    end
    logic [8:0] addr_c;
    assign addr_c = p_s + off_c;

    always_ff @(posedge aclk) begin
        if (cmd.wr_sample) ring[seen_reg[AW-1:0]] <= s_sample;
        rd_reg <= ring[addr_c[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg <= WW'(31);
            pad_reg      <= 1'b0;
            frac_reg     <= '0;
            seen_reg     <= '0;
            emitted_reg  <= '0;
            end_reg      <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    tsmf_pkg::CFG_WINDOW_SIZE:  win_size_reg <= cfg_data[WW-1:0];
                    tsmf_pkg::CFG_PADDING_MODE: pad_reg      <= cfg_data[0];
                    tsmf_pkg::CFG_DROP_FRAC:    frac_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.wr_sample) begin
                seen_reg <= tsmf_pkg::bump_count(seen_reg);
                end_reg  <= s_series_end;
            end
            if (cmd.bump_out) emitted_reg <= tsmf_pkg::bump_count(emitted_reg);
            if (cmd.clear_cnt) begin
                seen_reg    <= '0;
                emitted_reg <= '0;
            end
            rd_vld_reg <= cmd.gather;
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_out) begin
            w_reg      <= w_eff;
            v1_reg     <= v1_c;
            m_reg      <= m_c;
            pexact_reg <= emitted_reg < CW'(64);
            p_reg      <= emitted_reg[AW-1:0];
            rem_reg    <= lag_c;
            last_reg   <= end_reg && lag_c == AW'(1);
        end
        rd_k_reg <= cmd.tap;
        if (cmd.gather) sort_par_reg <= 1'b0;
        if (rd_vld_reg) win_reg[rd_k_reg] <= rd_reg;
        if (cmd.sort_step) begin
            sort_par_reg <= ~sort_par_reg;
            for (int i = 0; i < MAX_WINDOW - 1; i++) begin
                if (i[0] == sort_par_reg && (i + 1) < int'(w_reg)
                    && win_reg[i] > win_reg[i+1]) begin
                    win_reg[i]   <= win_reg[i+1];
                    win_reg[i+1] <= win_reg[i];
                end
            end
        end
        if (cmd.emit) begin
            if (m_reg[0])
                med_reg <= {win_reg[(m_reg-1'b1)>>1], 1'b0};
            else
                med_reg <= (SAMPLE_BITS+1)'(win_reg[(m_reg>>1)-1'b1])
                         + (SAMPLE_BITS+1)'(win_reg[m_reg>>1]);
            mlast_reg <= last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_median_x2      = med_reg;
    assign m_last_of_series = mlast_reg;

endmodule

### src/trimmed_sliding_median_filter_core.sv
// Sequential: one item at a time. An item that yields no result passes through
// idle, check and done; each result adds one check, W ring reads, one step for
// the last read to land, W+1 sort passes of one odd/even compare-exchange row
// and one emit, which also waits while the previous result is not taken.
// Reset (aresetn, sync, active low) loads window_size 31, padding_mode 0,
// drop_frac_q8 0 and zeroes counters.
module trimmed_sliding_median_filter_core #(
    parameter int MAX_WINDOW  = tsmf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = tsmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_series_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS:0]   m_median_x2,
    output logic                          m_last_of_series,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [7:0]                    cfg_data
);

    tsmf_pkg::tsmf_cmd_t cmd;
    tsmf_pkg::tsmf_sts_t sts;

    tsmf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_series_end(s_series_end), .sts(sts), .cmd(cmd)
    );

    tsmf_dp #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_sample(s_sample),
        .s_series_end(s_series_end), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd), .sts(sts), .m_valid(m_valid),
        .m_ready(m_ready), .m_median_x2(m_median_x2),
        .m_last_of_series(m_last_of_series)
    );

endmodule
